>>> rtl/vcbc_pkg.sv
// ----------------------------------------------------------------------------
// vcbc_pkg: shared types for the view cone batch culler
// Batch record, result record, configuration register, register index and alpha state types.
// ----------------------------------------------------------------------------
package vcbc_pkg;

    localparam int TOTAL_W = 31;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        CFG_VIEW_X      = 2'd0,
        CFG_VIEW_Y      = 2'd1,
        CFG_FORWARD_COS = 2'd2,
        CFG_FORWARD_SIN = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ALPHA_OFF     = 2'd0,
        ALPHA_ON      = 2'd1,
        ALPHA_UNKNOWN = 2'd2
    } alpha_state_t;

    typedef struct packed {
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic signed [15:0] forward_cos;
        logic signed [15:0] forward_sin;
    } vcbc_cfg_t;

    typedef struct packed {
        logic               frame_start;
        logic        [31:0] texture_id;
        logic        [31:0] buffer_id;
        logic signed [31:0] batch_vertices;
        logic               alpha_flag;
        logic signed [31:0] center_x;
        logic signed [31:0] center_z;
        logic signed [31:0] bound_radius;
    } vcbc_item_t;

    typedef struct packed {
        logic               draw;
        logic        [31:0] draw_buffer;
        logic [TOTAL_W-1:0] draw_count;
        logic               texture_change;
        logic               texture_enable;
        logic        [31:0] bind_texture;
        logic               alpha_change;
        logic               alpha_enable;
        logic [TOTAL_W-1:0] batches_total;
        logic [TOTAL_W-1:0] vertices_total;
    } vcbc_result_t;

endpackage

>>> rtl/vcbc_visibility.sv
// ----------------------------------------------------------------------------
// vcbc_visibility: bounding circle against view cone
// Projects the circle center on the forward and side axes and applies the
// near plane and cone tests, exact in units of 2^-31.
// ----------------------------------------------------------------------------
module vcbc_visibility
    import vcbc_pkg::*;
(
    input  vcbc_cfg_t   cfg,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_z,
    input  logic signed [31:0] bound_radius,
    output logic        visible
);

    localparam int CW = 56;

    localparam logic signed [CW-1:0] NEAR_LIM   = -56'sd274877906944;
    localparam logic signed [CW-1:0] FAR_SPLIT  = 56'sd137438953472;
    localparam logic signed [CW-1:0] CONE_BIAS  = 56'sd3298534883328;
    localparam logic signed [CW-1:0] SIDE_LIM   = 56'sd1374389534720;

    logic signed [33:0]   dx;
    logic signed [33:0]   dy;
    logic signed [49:0]   p_xc;
    logic signed [49:0]   p_ys;
    logic signed [49:0]   p_yc;
    logic signed [49:0]   p_xs;
    logic signed [CW-1:0] fwd;
    logic signed [CW-1:0] side;
    logic signed [CW-1:0] side_abs;
    logic signed [CW-1:0] rad;
    logic signed [CW-1:0] gap;
    logic signed [CW-1:0] gap_x4;
    logic signed [CW-1:0] fwd_x5;

    always_comb begin
        dx       = 34'(center_x) - 34'(cfg.view_x);
        dy       = -34'(center_z) - 34'(cfg.view_y);
        p_xc     = 50'(dx) * 50'(cfg.forward_cos);
        p_ys     = 50'(dy) * 50'(cfg.forward_sin);
        p_yc     = 50'(dy) * 50'(cfg.forward_cos);
        p_xs     = 50'(dx) * 50'(cfg.forward_sin);
        fwd      = CW'(p_xc) + CW'(p_ys);
        side     = CW'(p_yc) - CW'(p_xs);
        side_abs = side[CW-1] ? -side : side;
        rad      = CW'(bound_radius) <<< 15;
        gap      = side_abs - rad;
        gap_x4   = gap <<< 2;
        fwd_x5   = (fwd <<< 2) + fwd;

        if (fwd + rad < NEAR_LIM) begin
            visible = 1'b0;
        end else if (fwd > FAR_SPLIT) begin
            visible = !(gap_x4 > fwd_x5 + CONE_BIAS);
        end else begin
            visible = !(gap > SIDE_LIM);
        end
    end

endmodule

>>> rtl/vcbc_tracker.sv
// ----------------------------------------------------------------------------
// vcbc_tracker: bound state and frame totals
// Flags texture and alpha-test changes for drawn batches and keeps the
// saturating batch and vertex totals of the frame.
// ----------------------------------------------------------------------------
module vcbc_tracker
    import vcbc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  vcbc_item_t   item,
    input  logic         visible,
    input  logic         commit,
    output vcbc_result_t result
);

    logic        [31:0] texture_reg;
    logic        [31:0] texture_next;
    logic        [1:0]  alpha_reg;
    logic        [1:0]  alpha_next;
    logic [TOTAL_W-1:0] batches_reg;
    logic [TOTAL_W-1:0] batches_next;
    logic [TOTAL_W-1:0] vertices_reg;
    logic [TOTAL_W-1:0] vertices_next;

    logic        [31:0] texture_cur;
    logic        [1:0]  alpha_cur;
    logic [TOTAL_W-1:0] batches_cur;
    logic [TOTAL_W-1:0] vertices_cur;
    logic [TOTAL_W:0]   vertex_sum;
    logic [TOTAL_W-1:0] count;
    logic               drawn;

    always_comb begin
        // frame start clears bound state before this beat
        if (item.frame_start) begin
            texture_cur  = '1;
            alpha_cur    = ALPHA_UNKNOWN;
            batches_cur  = '0;
            vertices_cur = '0;
        end else begin
            texture_cur  = texture_reg;
            alpha_cur    = alpha_reg;
            batches_cur  = batches_reg;
            vertices_cur = vertices_reg;
        end

        drawn = (item.buffer_id != 32'd0) && !item.batch_vertices[31]
                && (item.batch_vertices != 32'sd0) && visible;
        count = item.batch_vertices[TOTAL_W-1:0];

        vertex_sum = {1'b0, vertices_cur} + {1'b0, count};

        texture_next  = texture_cur;
        alpha_next    = alpha_cur;
        batches_next  = batches_cur;
        vertices_next = vertices_cur;
        result        = '0;

        if (drawn) begin
            texture_next  = item.texture_id;
            alpha_next    = {1'b0, item.alpha_flag};
            batches_next  = (batches_cur == TOTAL_MAX) ? TOTAL_MAX
                                                       : batches_cur + 1'b1;
            vertices_next = vertex_sum[TOTAL_W] ? TOTAL_MAX
                                                : vertex_sum[TOTAL_W-1:0];

            result.draw           = 1'b1;
            result.draw_buffer    = item.buffer_id;
            result.draw_count     = count;
            result.texture_change = (item.texture_id != texture_cur);
            result.texture_enable = (item.texture_id != 32'd0);
            result.bind_texture   = item.texture_id;
            result.alpha_change   = ({1'b0, item.alpha_flag} != alpha_cur);
            result.alpha_enable   = item.alpha_flag;
        end

        result.batches_total  = batches_next;
        result.vertices_total = vertices_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            texture_reg  <= '1;
            alpha_reg    <= ALPHA_UNKNOWN;
            batches_reg  <= '0;
            vertices_reg <= '0;
        end else if (commit) begin
            texture_reg  <= texture_next;
            alpha_reg    <= alpha_next;
            batches_reg  <= batches_next;
            vertices_reg <= vertices_next;
        end
    end

endmodule

>>> rtl/view_cone_batch_culler.sv
// ----------------------------------------------------------------------------
// view_cone_batch_culler: batch culling against a 2-D view cone
// Culls batch records by bounding circle and reports the texture and
// alpha-test changes and frame totals for each drawn batch.
//
//   channel   dir  beat contents
//   s_axis    in   one batch record, tuser = frame start
//   m_axis    out  one result record per batch
//   cfg       in   register write, no read-back
//
// one beat per cycle sustained while m_tready is high; m_tvalid follows the input and result registers
// the cost is set by the projection multipliers and the cone compare,
// all between the input register and the result register
// stalls on m_tready hold the result register and back up into s_tready
// reset (aresetn low) clears valids, sets the default view and clears the totals and bound state
// ----------------------------------------------------------------------------
module view_cone_batch_culler
    import vcbc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,

    input  logic         s_tvalid,
    output logic         s_tready,
    // texture_id, buffer_id, batch_vertices, alpha_flag, center_x,
    // center_z, bound_radius
    input  logic [199:0] s_tdata,
    // frame_start
    input  logic         s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // draw, draw_buffer, draw_count, texture_change, texture_enable,
    // bind_texture, alpha_change, alpha_enable, batches_total, vertices_total
    output logic [167:0] m_tdata
);

    vcbc_cfg_t    cfg_reg;
    vcbc_item_t   item_reg;
    logic         item_valid_reg;
    vcbc_result_t result;
    vcbc_result_t result_reg;
    logic         result_valid_reg;
    logic         visible;
    logic         advance;
    logic         commit;

    assign advance  = !result_valid_reg || m_tready;
    assign s_tready = !item_valid_reg || advance;
    assign commit   = item_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.view_x      <= '0;
            cfg_reg.view_y      <= '0;
            cfg_reg.forward_cos <= 16'sd32767;
            cfg_reg.forward_sin <= '0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_VIEW_X:      cfg_reg.view_x      <= cfg_wdata;
                CFG_VIEW_Y:      cfg_reg.view_y      <= cfg_wdata;
                CFG_FORWARD_COS: cfg_reg.forward_cos <= cfg_wdata[15:0];
                CFG_FORWARD_SIN: cfg_reg.forward_sin <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.frame_start    <= s_tuser;
            item_reg.texture_id     <= s_tdata[31:0];
            item_reg.buffer_id      <= s_tdata[63:32];
            item_reg.batch_vertices <= s_tdata[95:64];
            item_reg.alpha_flag     <= s_tdata[96];
            item_reg.center_x       <= s_tdata[128:97];
            item_reg.center_z       <= s_tdata[160:129];
            item_reg.bound_radius   <= s_tdata[192:161];
        end
    end

    vcbc_visibility u_visibility (
        .cfg          (cfg_reg),
        .center_x     (item_reg.center_x),
        .center_z     (item_reg.center_z),
        .bound_radius (item_reg.bound_radius),
        .visible      (visible)
    );

    vcbc_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item_reg),
        .visible (visible),
        .commit  (commit),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = result_valid_reg;

    assign m_tdata = {
        6'd0,
        result_reg.vertices_total,
        result_reg.batches_total,
        result_reg.alpha_enable,
        result_reg.alpha_change,
        result_reg.bind_texture,
        result_reg.texture_enable,
        result_reg.texture_change,
        result_reg.draw_count,
        result_reg.draw_buffer,
        result_reg.draw
    };

endmodule

>>> sim/vcbc_cull_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vcbc_cull_monitor: result predictor and comparator for the batch culler
// Tracks the view registers and the bound texture, alpha and frame totals,
// predicts the result of every accepted batch and compares each result beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module vcbc_cull_monitor
    import vcbc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,

    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [199:0] s_tdata,
    input  logic         s_tuser,

    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [167:0] m_tdata,

    output int           pending,
    output int           mismatches
);

    localparam longint UNIT = 64'sd2147483648;

    vcbc_cfg_t          view_cfg;
    logic [31:0]        bound_texture;
    alpha_state_t       bound_alpha;
    logic [TOTAL_W-1:0] batch_count;
    logic [TOTAL_W-1:0] vertex_count;
    vcbc_result_t       awaited_results[$];

    function automatic void start_frame();
        bound_texture = '1;
        bound_alpha   = ALPHA_UNKNOWN;
        batch_count   = '0;
        vertex_count  = '0;
    endfunction

    function automatic logic cone_hit(input vcbc_item_t b);
        longint c, s, dx, dy, fwd, side, rad;
        c    = $signed(view_cfg.forward_cos);
        s    = $signed(view_cfg.forward_sin);
        dx   = longint'($signed(b.center_x)) - longint'($signed(view_cfg.view_x));
        dy   = -longint'($signed(b.center_z)) - longint'($signed(view_cfg.view_y));
        fwd  = dx * c + dy * s;
        side = dy * c - dx * s;
        rad  = longint'($signed(b.bound_radius)) * 32768;
        if (side < 0) begin
            side = -side;
        end
        if (fwd + rad < -128 * UNIT) begin
            return 1'b0;
        end
        if (fwd > 64 * UNIT) begin
            return !(4 * (side - rad) > 5 * fwd + 1536 * UNIT);
        end
        return !(side - rad > 640 * UNIT);
    endfunction

    function automatic vcbc_result_t cull_batch(input vcbc_item_t b);
        vcbc_result_t r;
        alpha_state_t wanted_alpha;
        longint       sum;
        if (b.frame_start) begin
            start_frame();
        end
        r = '0;
        wanted_alpha = b.alpha_flag ? ALPHA_ON : ALPHA_OFF;
        if (b.buffer_id != 0 && $signed(b.batch_vertices) > 0 && cone_hit(b)) begin
            r.draw           = 1'b1;
            r.draw_buffer    = b.buffer_id;
            r.draw_count     = b.batch_vertices[TOTAL_W-1:0];
            r.texture_change = (b.texture_id != bound_texture);
            r.texture_enable = (b.texture_id != 0);
            r.bind_texture   = b.texture_id;
            r.alpha_change   = (wanted_alpha != bound_alpha);
            r.alpha_enable   = b.alpha_flag;
            bound_texture    = b.texture_id;
            bound_alpha      = wanted_alpha;
            if (batch_count != TOTAL_MAX) begin
                batch_count = batch_count + 1'b1;
            end
            sum = longint'(vertex_count) + longint'($signed(b.batch_vertices));
            vertex_count = (sum > longint'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);
        end
        r.batches_total  = batch_count;
        r.vertices_total = vertex_count;
        return r;
    endfunction

    function automatic int field_miss(input string name, input longint unsigned want,
                                      input longint unsigned got);
        if (want == got) begin
            return 0;
        end
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin
        vcbc_item_t   b;
        vcbc_result_t got;
        vcbc_result_t want;
        if (!aresetn) begin
            view_cfg.view_x      = '0;
            view_cfg.view_y      = '0;
            view_cfg.forward_cos = 16'sd32767;
            view_cfg.forward_sin = '0;
            start_frame();
            awaited_results.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.draw           = m_tdata[0];
                got.draw_buffer    = m_tdata[32:1];
                got.draw_count     = m_tdata[63:33];
                got.texture_change = m_tdata[64];
                got.texture_enable = m_tdata[65];
                got.bind_texture   = m_tdata[97:66];
                got.alpha_change   = m_tdata[98];
                got.alpha_enable   = m_tdata[99];
                got.batches_total  = m_tdata[130:100];
                got.vertices_total = m_tdata[161:131];
                if (awaited_results.size() == 0) begin
                    $error("result beat with no batch outstanding");
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    mismatches += field_miss("draw", want.draw, got.draw)
                        + field_miss("draw_buffer", want.draw_buffer, got.draw_buffer)
                        + field_miss("draw_count", want.draw_count, got.draw_count)
                        + field_miss("texture_change", want.texture_change,
                                     got.texture_change)
                        + field_miss("texture_enable", want.texture_enable,
                                     got.texture_enable)
                        + field_miss("bind_texture", want.bind_texture, got.bind_texture)
                        + field_miss("alpha_change", want.alpha_change, got.alpha_change)
                        + field_miss("alpha_enable", want.alpha_enable, got.alpha_enable)
                        + field_miss("batches_total", want.batches_total,
                                     got.batches_total)
                        + field_miss("vertices_total", want.vertices_total,
                                     got.vertices_total);
                end
            end
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_VIEW_X:      view_cfg.view_x      = cfg_wdata;
                    CFG_VIEW_Y:      view_cfg.view_y      = cfg_wdata;
                    CFG_FORWARD_COS: view_cfg.forward_cos = cfg_wdata[15:0];
                    CFG_FORWARD_SIN: view_cfg.forward_sin = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                b.frame_start    = s_tuser;
                b.texture_id     = s_tdata[31:0];
                b.buffer_id      = s_tdata[63:32];
                b.batch_vertices = s_tdata[95:64];
                b.alpha_flag     = s_tdata[96];
                b.center_x       = s_tdata[128:97];
                b.center_z       = s_tdata[160:129];
                b.bound_radius   = s_tdata[192:161];
                awaited_results.push_back(cull_batch(b));
            end
        end
        pending <= awaited_results.size();
    end

endmodule

>>> sim/view_cone_batch_culler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// view_cone_batch_culler_tb: stream test of the view cone batch culler
// Drives directed edge-case batches, then phases of random batches under
// several view positions and yaw settings with random idle bursts on both
// channels; the monitor predicts and checks every result beat.
// ----------------------------------------------------------------------------
module view_cone_batch_culler_tb;
    import vcbc_pkg::*;

    localparam int CYCLE_LIMIT       = 300000;
    localparam int RANDOM_PHASES     = 8;
    localparam int BATCHES_PER_PHASE = 220;

    localparam logic signed [15:0] YAW_COS [8] = '{
        16'sd32767, 16'sd23170, 16'sd0, -16'sd23170,
        -16'sd32768, -16'sd23170, 16'sd0, 16'sd23170
    };
    localparam logic signed [15:0] YAW_SIN [8] = '{
        16'sd0, 16'sd23170, 16'sd32767, 16'sd23170,
        16'sd0, -16'sd23170, -16'sd32768, -16'sd23170
    };

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;

    int pending;
    int mismatches;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int sink_hold     = 0;
    int cycles;

    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;

    view_cone_batch_culler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    vcbc_cull_monitor cull_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
            @(posedge aclk);
        end
        $display("view_cone_batch_culler_tb failed");
        $finish;
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold != 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            m_tready  <= 1'b0;
            sink_hold <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic signed [31:0] fx(input int units);
        return units <<< 16;
    endfunction

    function automatic vcbc_item_t mk_batch(input logic fs, input logic [31:0] tex,
                                            input logic [31:0] buf_id, input int cnt,
                                            input logic alpha, input int cx, input int cz,
                                            input int r);
        vcbc_item_t b;
        b.frame_start    = fs;
        b.texture_id     = tex;
        b.buffer_id      = buf_id;
        b.batch_vertices = cnt;
        b.alpha_flag     = alpha;
        b.center_x       = cx;
        b.center_z       = cz;
        b.bound_radius   = r;
        return b;
    endfunction

    function automatic vcbc_item_t rand_batch();
        vcbc_item_t b;
        int unsigned pick;
        int off_x, off_y;
        b.frame_start = ($urandom_range(0, 39) == 0);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            b.texture_id = '0;
        end else if (pick < 7) begin
            b.texture_id = $urandom_range(1, 4);
        end else if (pick == 7) begin
            b.texture_id = '1;
        end else begin
            b.texture_id = $urandom;
        end
        b.buffer_id = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
        pick = $urandom_range(0, 19);
        if (pick < 17) begin
            b.batch_vertices = $urandom_range(1, 4000);
        end else if (pick == 17) begin
            b.batch_vertices = $urandom;
        end else if (pick == 18) begin
            b.batch_vertices = -int'($urandom_range(0, 3));
        end else begin
            b.batch_vertices = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
        end
        b.alpha_flag = $urandom_range(0, 1);
        if ($urandom_range(0, 99) < 85) begin
            off_x = (int'($urandom_range(0, 4000)) - 2000) * 65536
                    + int'($urandom_range(0, 65535));
            off_y = (int'($urandom_range(0, 4000)) - 2000) * 65536
                    + int'($urandom_range(0, 65535));
            b.center_x = eye_x + off_x;
            b.center_z = -(eye_y + off_y);
        end else begin
            b.center_x = $urandom;
            b.center_z = $urandom;
        end
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            b.bound_radius = $urandom_range(0, 300 * 65536);
        end else if (pick == 8) begin
            b.bound_radius = -int'($urandom_range(0, 50 * 65536));
        end else begin
            b.bound_radius = $urandom;
        end
        return b;
    endfunction

    task automatic push_batch(input vcbc_item_t b);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.frame_start;
        s_tdata  <= {7'd0, b.bound_radius, b.center_z, b.center_x, b.alpha_flag,
                     b.batch_vertices, b.buffer_id, b.texture_id};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_view(input logic signed [31:0] vx, input logic signed [31:0] vy,
                              input logic signed [15:0] c, input logic signed [15:0] s);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VIEW_X;
        cfg_wdata <= vx;
        @(posedge aclk);
        cfg_index <= CFG_VIEW_Y;
        cfg_wdata <= vy;
        @(posedge aclk);
        cfg_index <= CFG_FORWARD_COS;
        cfg_wdata <= 32'(c);
        @(posedge aclk);
        cfg_index <= CFG_FORWARD_SIN;
        cfg_wdata <= 32'(s);
        @(posedge aclk);
        cfg_we <= 1'b0;
        eye_x = vx;
        eye_y = vy;
    endtask

    initial begin
        int p;
        int i;
        int unsigned yaw;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_VIEW_X;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        eye_x = '0;
        eye_y = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // edge cases under the reset view
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        push_batch(mk_batch(1, 5, 1, 3, 0, fx(10), 0, fx(1)));
        push_batch(mk_batch(0, 5, 2, 4, 0, fx(20), fx(5), fx(2)));
        push_batch(mk_batch(0, 0, 3, 1, 1, 0, 0, 0));
        push_batch(mk_batch(1, '1, 4, 2, 1, fx(1), 0, 0));
        push_batch(mk_batch(0, 7, 0, 10, 0, fx(5), 0, fx(1)));
        push_batch(mk_batch(0, 7, 5, 0, 0, fx(5), 0, fx(1)));
        push_batch(mk_batch(0, 7, 6, 32'h8000_0000, 0, fx(5), 0, fx(1)));
        push_batch(mk_batch(0, 7, 7, 32'h7FFF_FFFF, 0, fx(5), 0, fx(1)));
        push_batch(mk_batch(0, 7, 8, 32'h7FFF_FFFF, 1, fx(6), 0, fx(1)));
        push_batch(mk_batch(0, 7, 9, 5, 0, fx(-200), 0, fx(10)));
        push_batch(mk_batch(0, 7, 10, 5, 0, fx(-130), 0, fx(1)));
        push_batch(mk_batch(0, 7, 11, 5, 0, fx(-127), 0, 0));
        push_batch(mk_batch(0, 8, 12, 6, 1, fx(100), fx(600), 0));
        push_batch(mk_batch(0, 8, 13, 6, 1, fx(100), fx(-500), 0));
        push_batch(mk_batch(0, 8, 14, 6, 1, 0, fx(639), 0));
        push_batch(mk_batch(0, 8, 15, 6, 1, 0, fx(641), 0));
        push_batch(mk_batch(0, 8, 16, 6, 1, 0, fx(600), fx(-50)));
        push_batch(mk_batch(0, 9, 17, 6, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        push_batch(mk_batch(0, 9, 18, 6, 0, fx(1), 0, 32'h8000_0000));
        push_batch(mk_batch(1, '1, '1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF));
        push_batch(mk_batch(0, 0, 0, 0, 0, 0, 0, 0));
        push_batch(mk_batch(1, 3, 0, 1, 0, 0, 0, 0));
        drain();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            yaw = $urandom_range(0, 7);
            case (p)
                0: begin
                    src_idle_pct  = 20;
                    sink_idle_pct = 20;
                    write_view(fx(100), fx(-50), YAW_COS[2], YAW_SIN[2]);
                end
                1: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 40;
                    write_view(32'h7FFF_FFFF, 32'h8000_0000, -16'sd32768, 16'sd0);
                end
                2: begin
                    src_idle_pct  = 40;
                    sink_idle_pct = 0;
                    write_view(32'h8000_0000, 32'h7FFF_FFFF, YAW_COS[7], YAW_SIN[7]);
                end
                3: begin
                    src_idle_pct  = 30;
                    sink_idle_pct = 30;
                    write_view($urandom, $urandom, 16'($urandom), 16'($urandom));
                end
                4: begin
                    src_idle_pct  = 10;
                    sink_idle_pct = 10;
                    write_view(0, 0, -16'sd32768, -16'sd32768);
                end
                5: begin
                    src_idle_pct  = 50;
                    sink_idle_pct = 50;
                    write_view(fx(int'($urandom_range(0, 2000)) - 1000),
                               fx(int'($urandom_range(0, 2000)) - 1000),
                               16'sd32767, 16'sd32767);
                end
                6: begin
                    src_idle_pct  = 20;
                    sink_idle_pct = 20;
                    write_view(fx(int'($urandom_range(0, 2000)) - 1000),
                               fx(int'($urandom_range(0, 2000)) - 1000),
                               YAW_COS[yaw], YAW_SIN[yaw]);
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    write_view(0, 0, 16'sd32767, 16'sd0);
                end
            endcase
            for (i = 0; i < BATCHES_PER_PHASE; i++) begin
                push_batch(rand_batch());
            end
            drain();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("view_cone_batch_culler_tb passed");
        end else begin
            $display("view_cone_batch_culler_tb failed");
        end
        $finish;
    end

endmodule
